// File: src/rmob_pkg.sv
// ============================================================================
// rmob_pkg: shared types and tables of the RAM-mapped output board
// Word formats, access and update codes, segment and coil tables.
// ============================================================================
package rmob_pkg;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	localparam logic [1:0] UPD_NONE  = 2'd0;
	localparam logic [1:0] UPD_DIGIT = 2'd1;
	localparam logic [1:0] UPD_LAMP  = 2'd2;
	localparam logic [1:0] UPD_SOL   = 2'd3;

	// lamp store: entry c (0..7) holds {column c+8, column c}, entry 8 holds column 16
	localparam int         LAMP_ENTRIES  = 9;
	localparam int         LAMP_AW       = 4;
	localparam logic [3:0] LAMP_UP_ENTRY = 4'd8;

	localparam logic [19:0] COIL_MAP [20] = '{
		20'h00001, 20'h00010, 20'h04000, 20'h00040,
		20'h00002, 20'h00020, 20'h00008, 20'h08000,
		20'h00800, 20'h00004, 20'h00080, 20'h02000,
		20'h00400, 20'h00200, 20'h00100, 20'h01000,
		20'h20000, 20'h10000, 20'h40000, 20'h80000
	};

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] address;
		logic [7:0]  write_data;
	} req_word_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [1:0]  update_kind;
		logic [5:0]  target_index;
		logic [7:0]  pattern;
		logic [27:0] solenoid_word;
		logic        last;
	} rsp_word_t;

	// decode results and state updates of one access
	typedef struct packed {
		rsp_word_t   res0;
		rsp_word_t   res1;
		logic        two;
		logic        ram_we;
		logic        lamp_we;
		logic [3:0]  lamp_waddr;
		logic [15:0] lamp_wdata;
		logic        latch_we;
		logic [27:0] accum_next;
	} exec_t;

	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'h3f;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5b;
			4'd3: s = 8'h4f;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6d;
			4'd6: s = 8'h7c;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7f;
			4'd9: s = 8'h67;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	// latches 0..2 drive their top nibble, latch 3 all eight bits
	function automatic logic [19:0] coil_bits(input logic [1:0] idx, input logic [7:0] v);
		logic [19:0] acc;
		logic [4:0]  k;
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			k = 5'(4 * int'(idx) + i);
			if ((idx == 2'd3 || i < 4) && v[7 - i]) begin
				acc = acc | COIL_MAP[k];
			end
		end
		return acc;
	endfunction

endpackage

// File: src/rmob_ram.sv
// ============================================================================
// rmob_ram: generic single-port-write, single-port-read RAM
// One write port, one read port with registered read data.
// ============================================================================
module rmob_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/rmob_exec.sv
// ============================================================================
// rmob_exec: access decoder of the output board
// Turns one access plus the fetched RAM and lamp bytes into results and updates.
// ============================================================================
module rmob_exec (
	input  rmob_pkg::req_word_t item,
	input  logic [7:0]          ram_rd,
	input  logic [15:0]         lamp_rd,
	input  logic [7:0]          latch_rd,
	input  logic [27:0]         accum,
	output rmob_pkg::exec_t     ex
);

	logic [15:0] a;
	logic [7:0]  v;
	logic [8:0]  off;
	logic        dec_region;
	logic        is_latch;
	logic [7:0]  up_bit;
	logic [7:0]  up_col;
	logic [2:0]  col;
	logic [7:0]  lo_new;
	logic [7:0]  hi_new;

	assign a          = item.address;
	assign v          = item.write_data;
	assign off        = a[8:0];
	assign dec_region = (a < 16'h0200) || (a >= 16'h1000 && a < 16'h1080);
	assign is_latch   = (a[15:4] == 12'h108) && (a[1:0] == 2'b00);
	assign up_bit     = 8'h08 >> off[3:2];
	assign up_col     = (v[3:0] == 4'h8) ? (lamp_rd[7:0] | up_bit) : (lamp_rd[7:0] & ~up_bit);
	assign col        = {off[1:0], off[3]};
	assign lo_new     = off[2] ? {v[3:0], lamp_rd[3:0]} : {lamp_rd[7:4], v[3:0]};
	assign hi_new     = off[2] ? {v[7:4], lamp_rd[11:8]} : {lamp_rd[15:12], v[7:4]};

	always_comb begin
		ex            = '0;
		ex.accum_next = accum;
		case (item.kind)
			rmob_pkg::KIND_READ: begin
				if (a < 16'h0200) begin
					ex.res0.read_data = ram_rd;
				end else if (is_latch) begin
					ex.res0.read_data = latch_rd;
				end
			end
			rmob_pkg::KIND_WRITE: begin
				if (dec_region) begin
					ex.ram_we = 1'b1;
					if (off < 9'h010) begin
						if (off[1:0] == 2'b11) begin
							// player-up lamp bit in column 16
							ex.lamp_we                = 1'b1;
							ex.lamp_waddr             = rmob_pkg::LAMP_UP_ENTRY;
							ex.lamp_wdata             = {8'h00, up_col};
							ex.res0.update_kind  = rmob_pkg::UPD_LAMP;
							ex.res0.target_index = 6'd16;
							ex.res0.pattern      = up_col;
						end else begin
							ex.two               = 1'b1;
							ex.res0.update_kind  = rmob_pkg::UPD_DIGIT;
							ex.res0.target_index = 6'd30 - {1'b0, off[3:0], 1'b0};
							ex.res0.pattern      = rmob_pkg::seg_of(v[7:4]);
							ex.res1.update_kind  = rmob_pkg::UPD_DIGIT;
							ex.res1.target_index = 6'd31 - {1'b0, off[3:0], 1'b0};
							ex.res1.pattern      = rmob_pkg::seg_of(v[3:0]);
						end
					end else if (off == 9'h01c || off == 9'h01d) begin
						// match / credit digits
						ex.two               = 1'b1;
						ex.res0.update_kind  = rmob_pkg::UPD_DIGIT;
						ex.res0.target_index = {4'b1000, off[0], 1'b0};
						ex.res0.pattern      = rmob_pkg::seg_of(v[7:4]);
						ex.res1.update_kind  = rmob_pkg::UPD_DIGIT;
						ex.res1.target_index = {4'b1000, off[0], 1'b1};
						ex.res1.pattern      = rmob_pkg::seg_of(v[3:0]);
					end else if (off[8:4] == 5'h03) begin
						ex.two               = 1'b1;
						ex.lamp_we           = 1'b1;
						ex.lamp_waddr        = {1'b0, col};
						ex.lamp_wdata        = {hi_new, lo_new};
						ex.res0.update_kind  = rmob_pkg::UPD_LAMP;
						ex.res0.target_index = {3'b000, col};
						ex.res0.pattern      = lo_new;
						ex.res1.update_kind  = rmob_pkg::UPD_LAMP;
						ex.res1.target_index = {3'b001, col};
						ex.res1.pattern      = hi_new;
					end
				end else if (a >= 16'h1080 && a < 16'h1200) begin
					if (is_latch) begin
						ex.latch_we   = 1'b1;
						ex.accum_next = accum | {8'h00, rmob_pkg::coil_bits(a[3:2], v)};
					end else begin
						ex.ram_we = 1'b1;
					end
				end else if (a == 16'h508c) begin
					ex.accum_next = accum | {v, 20'h00000};
				end
			end
			rmob_pkg::KIND_TICK: begin
				ex.res0.update_kind   = rmob_pkg::UPD_SOL;
				ex.res0.solenoid_word = accum;
				ex.accum_next         = '0;
			end
			default: begin
			end
		endcase
		if (ex.two) begin
			ex.res1.last = 1'b1;
		end else begin
			ex.res0.last = 1'b1;
		end
	end

endmodule

// File: src/ram_mapped_output_board.sv
// ============================================================================
// ram_mapped_output_board: work RAM that drives displays, lamps and coils
// Bus reads, writes and frame ticks in; digit, lamp and solenoid updates out.
// ============================================================================
//
//   channel  direction  handshake              word
//   req      in         req_valid / req_ready  rmob_pkg::req_word_t
//   rsp      out        rsp_valid / rsp_ready  rmob_pkg::rsp_word_t
//
// An access is taken while the work RAM and the lamp store are read; it is
// then decoded, written back and loaded into the result buffer once that
// buffer is empty, and only after that is a new access accepted.
// A write with two results delays the decode of the next access until both drain.
// After reset a clearing pass zeroes the work RAM (and the lamp store along
// with it) with req_ready low.
// A stalled rsp side holds the decode step until the result buffer empties.
module ram_mapped_output_board #(
	parameter int RAM_BYTES = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  rmob_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output rmob_pkg::rsp_word_t rsp
);

	localparam int AW = $clog2(RAM_BYTES);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_q;
	rmob_pkg::req_word_t item_s1;
	rmob_pkg::rsp_word_t buf0_q;
	rmob_pkg::rsp_word_t buf1_q;
	logic [1:0]          cnt_q;
	logic [7:0]          latch_q [4];
	logic [27:0]         accum_q;

	logic                req_fire;
	logic                rsp_fire;
	logic                exec_fire;
	logic                clearing;
	rmob_pkg::exec_t     ex;

	logic [7:0]          ram_rd;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [7:0]          ram_wdata;

	logic [15:0]         lamp_rd;
	logic                lamp_we;
	logic [3:0]          lamp_waddr;
	logic [15:0]         lamp_wdata;
	logic [3:0]          lamp_raddr;

	// offsets stay below 2*RAM_BYTES, so one compare and subtract wraps them
	function automatic logic [AW-1:0] ram_index(input logic [8:0] off);
		logic [9:0] raw;
		raw = {1'b0, off};
		if (raw >= 10'(RAM_BYTES)) begin
			raw = raw - 10'(RAM_BYTES);
		end
		return raw[AW-1:0];
	endfunction

	assign clearing  = (state_q == ST_CLEAR);
	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = (cnt_q != 2'd0);
	assign rsp       = buf0_q;
	assign rsp_fire  = rsp_valid && rsp_ready;
	// decode only into an empty buffer
	assign exec_fire = (state_q == ST_EXEC) && (cnt_q == 2'd0);

	// lamp entry: a lamp byte reads its column pair, anything else column 16
	assign lamp_raddr = (req.address[5:4] == 2'b11) ?
		{1'b0, req.address[1:0], req.address[3]} : rmob_pkg::LAMP_UP_ENTRY;

	assign ram_we    = clearing || (exec_fire && ex.ram_we);
	assign ram_waddr = clearing ? clr_q : ram_index(item_s1.address[8:0]);
	assign ram_wdata = clearing ? 8'h00 : item_s1.write_data;

	assign lamp_we    = clearing ? (clr_q < AW'(rmob_pkg::LAMP_ENTRIES)) :
		(exec_fire && ex.lamp_we);
	assign lamp_waddr = clearing ? clr_q[rmob_pkg::LAMP_AW-1:0] : ex.lamp_waddr;
	assign lamp_wdata = clearing ? 16'h0000 : ex.lamp_wdata;

	rmob_ram #(
		.WIDTH(8),
		.DEPTH(RAM_BYTES)
	) u_work_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (req_fire),
		.raddr(ram_index(req.address[8:0])),
		.rdata(ram_rd)
	);

	rmob_ram #(
		.WIDTH(16),
		.DEPTH(rmob_pkg::LAMP_ENTRIES)
	) u_lamp_ram (
		.clk  (clk),
		.we   (lamp_we),
		.waddr(lamp_waddr),
		.wdata(lamp_wdata),
		.re   (req_fire),
		.raddr(lamp_raddr),
		.rdata(lamp_rd)
	);

	rmob_exec u_exec (
		.item    (item_s1),
		.ram_rd  (ram_rd),
		.lamp_rd (lamp_rd),
		.latch_rd(latch_q[item_s1.address[3:2]]),
		.accum   (accum_q),
		.ex      (ex)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			cnt_q   <= 2'd0;
			accum_q <= '0;
			for (int i = 0; i < 4; i++) begin
				latch_q[i] <= 8'h00;
			end
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(RAM_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// result buffer: load on decode, shift on each taken word
			if (exec_fire) begin
				buf0_q  <= ex.res0;
				buf1_q  <= ex.res1;
				cnt_q   <= ex.two ? 2'd2 : 2'd1;
				accum_q <= ex.accum_next;
				if (ex.latch_we) begin
					latch_q[item_s1.address[3:2]] <= item_s1.write_data;
				end
			end else if (rsp_fire) begin
				buf0_q <= buf1_q;
				cnt_q  <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_s1 <= req;
		end
	end

endmodule

// File: src/rmob_checker.sv
// ============================================================================
// rmob_checker: port-level checks of the output board
// Watches both channels and the shape of each result word.
// ============================================================================
module rmob_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input rmob_pkg::req_word_t req,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input rmob_pkg::rsp_word_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp word changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("access taken while previous one in decode");

	a_read_only_plain: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.update_kind != rmob_pkg::UPD_NONE |-> rsp.read_data == 8'h00)
		else $error("read data on an update word");

	a_sol_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.update_kind == rmob_pkg::UPD_SOL |->
		rsp.last && rsp.target_index == 6'd0 && rsp.pattern == 8'h00)
		else $error("malformed solenoid word");

	a_sol_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.update_kind != rmob_pkg::UPD_SOL |-> rsp.solenoid_word == 28'd0)
		else $error("solenoid bits outside a tick word");

endmodule

bind ram_mapped_output_board rmob_checker u_rmob_checker (.*);

// File: test/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking testbench of ram_mapped_output_board
// Bus reads, writes and frame ticks go in through a valid/ready driver. A
// behavioral model of the board predicts the digit, lamp and coil updates for
// each access, and a monitor checks every result word field by field in order.
// ============================================================================
module tb;

	localparam int         RAM_BYTES  = 512;
	localparam logic [1:0] KIND_SPARE = 2'd3;  // unused access code, must be inert
	localparam int         ITEMS      = 550;
	localparam int         LIMIT      = 400000;
	localparam int         SETTLE     = 20;    // cycles allowed for stray results at the end
	localparam int         HOLD_AT    = 150;   // result count that starts the long back-pressure
	localparam int         HOLD_LEN   = 400;

	// seven-segment patterns, gfedcba; codes 10..15 show blank
	localparam logic [0:15][7:0] SEG_TABLE = {
		8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7c, 8'h07,
		8'h7f, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	// latch bit (latch*4 + position from the msb) to coil bit
	localparam logic [0:19][19:0] COIL_TABLE = {
		20'h00001, 20'h00010, 20'h04000, 20'h00040,
		20'h00002, 20'h00020, 20'h00008, 20'h08000,
		20'h00800, 20'h00004, 20'h00080, 20'h02000,
		20'h00400, 20'h00200, 20'h00100, 20'h01000,
		20'h20000, 20'h10000, 20'h40000, 20'h80000
	};

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	rmob_pkg::req_word_t req       = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	rmob_pkg::rsp_word_t rsp;

	// board image kept by the predictor
	logic [7:0]  ram_img   [RAM_BYTES];
	logic [7:0]  lamp_img  [17];
	logic [7:0]  latch_img [5];
	logic [27:0] coil_accum;

	rmob_pkg::req_word_t bus_q[$];      // accesses not yet offered to the board
	rmob_pkg::rsp_word_t due_q[$];      // result words owed by the board, oldest first

	int n_errors;
	int n_taken;
	int n_words;
	int n_cycles;
	int n_by_kind [4];
	int n_by_upd  [4];
	int send_gap;
	int stall_left;
	bit held;

	always #5 clk = ~clk;

	ram_mapped_output_board #(
		.RAM_BYTES(RAM_BYTES)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// idle lengths: mostly none or short, now and then long
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit is_latch(input logic [15:0] a);
		return a[15:4] == 12'h108 && a[1:0] == 2'b00;
	endfunction

	function automatic void queue_access(input logic [1:0] k, input logic [15:0] a,
			input logic [7:0] d);
		rmob_pkg::req_word_t w;
		w.kind       = k;
		w.address    = a;
		w.write_data = d;
		bus_q.push_back(w);
	endfunction

	// decoded RAM write at offset off: score and match/credit digits,
	// player-up lamps, nibble-merged lamp columns
	task automatic decode_write(input logic [15:0] off, input logic [7:0] v,
			inout rmob_pkg::rsp_word_t r0, inout rmob_pkg::rsp_word_t r1,
			inout bit two);
		logic [7:0] up_bit;
		int o;
		int col;
		ram_img[off % RAM_BYTES] = v;
		if (off < 16'h0010) begin
			if (off[1:0] == 2'd3) begin
				// player-up byte: low nibble 8 lights the lamp, anything else clears it
				up_bit = 8'h08 >> off[3:2];
				if (v[3:0] == 4'h8)
					lamp_img[16] = lamp_img[16] | up_bit;
				else
					lamp_img[16] = lamp_img[16] & ~up_bit;
				r0.update_kind  = rmob_pkg::UPD_LAMP;
				r0.target_index = 6'd16;
				r0.pattern      = lamp_img[16];
			end else begin
				two             = 1'b1;
				r0.update_kind  = rmob_pkg::UPD_DIGIT;
				r0.target_index = 6'(30 - 2 * int'(off));
				r0.pattern      = SEG_TABLE[v[7:4]];
				r1.update_kind  = rmob_pkg::UPD_DIGIT;
				r1.target_index = 6'(31 - 2 * int'(off));
				r1.pattern      = SEG_TABLE[v[3:0]];
			end
		end else if (off == 16'h001c || off == 16'h001d) begin
			o               = int'(off) - 28;
			two             = 1'b1;
			r0.update_kind  = rmob_pkg::UPD_DIGIT;
			r0.target_index = 6'(32 + 2 * o);
			r0.pattern      = SEG_TABLE[v[7:4]];
			r1.update_kind  = rmob_pkg::UPD_DIGIT;
			r1.target_index = 6'(33 + 2 * o);
			r1.pattern      = SEG_TABLE[v[3:0]];
		end else if (off >= 16'h0030 && off < 16'h0040) begin
			o   = int'(off) - 48;
			col = (o % 4) * 2 + o / 8;
			// first four bytes of each half fill low nibbles, the next four high
			if (o % 8 < 4) begin
				lamp_img[col][3:0]     = v[3:0];
				lamp_img[col + 8][3:0] = v[7:4];
			end else begin
				lamp_img[col][7:4]     = v[3:0];
				lamp_img[col + 8][7:4] = v[7:4];
			end
			two             = 1'b1;
			r0.update_kind  = rmob_pkg::UPD_LAMP;
			r0.target_index = 6'(col);
			r0.pattern      = lamp_img[col];
			r1.update_kind  = rmob_pkg::UPD_LAMP;
			r1.target_index = 6'(col + 8);
			r1.pattern      = lamp_img[col + 8];
		end
	endtask

	// update the board image for one taken access and queue the words it owes
	task automatic predict_access(input rmob_pkg::req_word_t w);
		rmob_pkg::rsp_word_t r0;
		rmob_pkg::rsp_word_t r1;
		bit                  two;
		logic [15:0]         a;
		logic [1:0]          li;
		logic [7:0]          v;
		r0  = '0;
		r1  = '0;
		two = 1'b0;
		a   = w.address;
		v   = w.write_data;
		li  = a[3:2];
		n_by_kind[w.kind]++;
		case (w.kind)
			rmob_pkg::KIND_READ: begin
				if (a < 16'h0200)
					r0.read_data = ram_img[a % RAM_BYTES];
				else if (is_latch(a))
					r0.read_data = latch_img[li];
			end
			rmob_pkg::KIND_WRITE: begin
				if (a < 16'h0200) begin
					decode_write(a, v, r0, r1, two);
				end else if (a >= 16'h1000 && a < 16'h1080) begin
					decode_write(a - 16'h1000, v, r0, r1, two);
				end else if (is_latch(a)) begin
					// latches 0..2 fire only with a nonzero top nibble, latch 3 on any bit
					latch_img[li] = v;
					if (li == 2'd3 || v[7:4] != 4'h0) begin
						for (int i = 0; i < 8; i++) begin
							if ((li == 2'd3 || i < 4) && v[7 - i])
								coil_accum = coil_accum | 28'(COIL_TABLE[4 * int'(li) + i]);
						end
					end
				end else if (a >= 16'h1080 && a < 16'h1200) begin
					ram_img[(a - 16'h1000) % RAM_BYTES] = v;
				end else if (a == 16'h508c) begin
					latch_img[4] = v;
					coil_accum   = coil_accum | {v, 20'h00000};
				end
			end
			rmob_pkg::KIND_TICK: begin
				r0.update_kind   = rmob_pkg::UPD_SOL;
				r0.solenoid_word = coil_accum;
				coil_accum       = '0;
			end
			default: ;
		endcase
		if (two) begin
			r1.last = 1'b1;
			due_q.push_back(r0);
			due_q.push_back(r1);
		end else begin
			r0.last = 1'b1;
			due_q.push_back(r0);
		end
	endtask

	task automatic check_field(input string nm, input logic [27:0] want, input logic [27:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, want, got);
			n_errors++;
		end
	endtask

	task automatic check_word(input rmob_pkg::rsp_word_t got);
		rmob_pkg::rsp_word_t want;
		if (due_q.size() == 0) begin
			$display("%0t: unexpected result word, expected none, actual %h", $time, got);
			n_errors++;
		end else begin
			want = due_q.pop_front();
			check_field("read_data", want.read_data, got.read_data);
			check_field("update_kind", want.update_kind, got.update_kind);
			check_field("target_index", want.target_index, got.target_index);
			check_field("pattern", want.pattern, got.pattern);
			check_field("solenoid_word", want.solenoid_word, got.solenoid_word);
			check_field("last", want.last, got.last);
			n_by_upd[got.update_kind]++;
		end
	endtask

	// driver: offers the next access once the current one is taken,
	// with random gaps; every third block of 64 accesses runs gap-free
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			send_gap  = 0;
		end else begin
			if (req_valid && req_ready) begin
				predict_access(req);
				n_taken++;
			end
			if (!req_valid || req_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (bus_q.size() > 0) begin
					req       <= bus_q.pop_front();
					req_valid <= 1'b1;
					send_gap  = ((n_taken / 64) % 3 == 2) ? 0 : pick_len();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result word, stalls at random, and once holds
	// off long enough for the board to fill up and refuse accesses
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready  <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				check_word(rsp);
				n_words++;
				if (n_words == HOLD_AT && !held) begin
					stall_left = HOLD_LEN;
					held       = 1'b1;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				stall_left = ((n_words / 80) % 3 == 1) ? 0 : pick_len();
				rsp_ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= LIMIT) begin
			$display("%0t: timeout, %0d result words still owed", $time, due_q.size());
			$display("ram_mapped_output_board verification failed");
			$finish;
		end
	end

	initial begin
		int          r;
		logic [1:0]  k;
		logic [15:0] a;
		int          n_directed;

		for (int i = 0; i < RAM_BYTES; i++)
			ram_img[i] = '0;
		for (int i = 0; i < 17; i++)
			lamp_img[i] = '0;
		for (int i = 0; i < 5; i++)
			latch_img[i] = '0;
		coil_accum = '0;

		// directed: field extremes, every decode region and the corner cases
		queue_access(rmob_pkg::KIND_READ,  16'h0000, 8'h00);  // RAM cleared by reset
		queue_access(rmob_pkg::KIND_WRITE, 16'h0000, 8'h09);  // top score digits 30/31
		queue_access(rmob_pkg::KIND_WRITE, 16'h000e, 8'hff);  // digit codes above 9 blank
		queue_access(rmob_pkg::KIND_WRITE, 16'h0003, 8'h08);  // player-up lamp on
		queue_access(rmob_pkg::KIND_WRITE, 16'h000f, 8'h18);  // low nibble decides
		queue_access(rmob_pkg::KIND_WRITE, 16'h0003, 8'h07);  // player-up lamp off
		queue_access(rmob_pkg::KIND_WRITE, 16'h001c, 8'h12);  // match digits
		queue_access(rmob_pkg::KIND_WRITE, 16'h101d, 8'h34);  // credit digits, mirror
		queue_access(rmob_pkg::KIND_WRITE, 16'h0030, 8'ha5);  // lamp low nibbles
		queue_access(rmob_pkg::KIND_WRITE, 16'h003f, 8'h5a);  // lamp high nibbles
		queue_access(rmob_pkg::KIND_WRITE, 16'h1034, 8'hff);
		queue_access(rmob_pkg::KIND_WRITE, 16'h1080, 8'h0f);  // no strobe: no coils
		queue_access(rmob_pkg::KIND_WRITE, 16'h1084, 8'hf0);
		queue_access(rmob_pkg::KIND_WRITE, 16'h1088, 8'h80);
		queue_access(rmob_pkg::KIND_WRITE, 16'h108c, 8'hff);  // latch 3 uses all eight bits
		queue_access(rmob_pkg::KIND_WRITE, 16'h508c, 8'hff);  // extra latch, coils 20..27
		queue_access(rmob_pkg::KIND_READ,  16'h108c, 8'h00);
		queue_access(rmob_pkg::KIND_TICK,  16'h0000, 8'h00);
		queue_access(rmob_pkg::KIND_TICK,  16'hffff, 8'hff);  // word cleared by first tick
		queue_access(rmob_pkg::KIND_WRITE, 16'h11ff, 8'h77);  // plain store, no decode
		queue_access(rmob_pkg::KIND_READ,  16'h01ff, 8'h00);
		queue_access(rmob_pkg::KIND_WRITE, 16'hffff, 8'h55);  // unmapped write ignored
		queue_access(rmob_pkg::KIND_READ,  16'h0200, 8'h00);  // unmapped read gives zero
		queue_access(KIND_SPARE,           16'habcd, 8'h12);
		queue_access(rmob_pkg::KIND_WRITE, 16'h0040, 8'h00);  // RAM without decode
		n_directed = bus_q.size();

		// random: mostly the decoded regions and latches, some noise
		for (int i = 0; i < ITEMS - n_directed; i++) begin
			r = $urandom_range(0, 99);
			if (r < 22)
				k = rmob_pkg::KIND_READ;
			else if (r < 82)
				k = rmob_pkg::KIND_WRITE;
			else if (r < 95)
				k = rmob_pkg::KIND_TICK;
			else
				k = KIND_SPARE;
			r = $urandom_range(0, 99);
			if (r < 18)
				a = 16'($urandom_range(0, 15));
			else if (r < 24)
				a = 16'h001c + 16'($urandom_range(0, 1));
			else if (r < 40)
				a = 16'h0030 + 16'($urandom_range(0, 15));
			else if (r < 52)
				a = 16'($urandom_range(0, 16'h01ff));
			else if (r < 58)
				a = 16'($urandom_range(16'h1000, 16'h107f));
			else if (r < 72)
				a = 16'h1080 + 16'(4 * $urandom_range(0, 3));
			else if (r < 78)
				a = 16'($urandom_range(16'h1081, 16'h11ff));
			else if (r < 83)
				a = 16'h508c;
			else
				a = 16'($urandom);
			// decoded regions also through the mirror
			if (r < 40 && $urandom_range(0, 1) == 1)
				a = a | 16'h1000;
			queue_access(k, a, 8'($urandom));
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (bus_q.size() > 0 || req_valid)
			@(posedge clk);
		while (due_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("accesses taken: %0d reads, %0d writes, %0d ticks, %0d unused-code",
			n_by_kind[rmob_pkg::KIND_READ], n_by_kind[rmob_pkg::KIND_WRITE],
			n_by_kind[rmob_pkg::KIND_TICK], n_by_kind[KIND_SPARE]);
		$display("words checked: %0d plain, %0d digit, %0d lamp, %0d coil; long hold %0s",
			n_by_upd[rmob_pkg::UPD_NONE], n_by_upd[rmob_pkg::UPD_DIGIT],
			n_by_upd[rmob_pkg::UPD_LAMP], n_by_upd[rmob_pkg::UPD_SOL],
			held ? "done" : "not reached");
		if (n_errors == 0)
			$display("ram_mapped_output_board verification clean");
		else
			$display("ram_mapped_output_board verification failed");
		$finish;
	end

endmodule

// File: filelist.f
src/rmob_pkg.sv
src/rmob_ram.sv
src/rmob_exec.sv
src/ram_mapped_output_board.sv
src/rmob_checker.sv
test/tb.sv
